@@ hdl/mbe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mbe_pkg: shared types and constants of the modular binomial engine
// Prime modulus, table geometry, reduction constant, operation codes and the
// request/result item structs.
// ---------------------------------------------------------------------------
package mbe_pkg;

    localparam int unsigned TABLE_SIZE = 4096;
    localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);

    localparam logic [29:0] MOD_P      = 30'd998244353;
    localparam logic [29:0] MOD_P_M2   = 30'd998244351;

    // Barrett constant floor(2^60 / P); fits in 31 bits
    localparam logic [63:0] BARRETT_FULL = (64'd1 << 60) / 64'd998244353;
    localparam logic [30:0] BARRETT_M    = BARRETT_FULL[30:0];

    // Operation codes
    localparam logic [1:0] FUNC_BINOM = 2'd0;
    localparam logic [1:0] FUNC_POW   = 2'd1;
    localparam logic [1:0] FUNC_INV   = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [29:0]        base;
        logic [61:0]        exponent;
        logic signed [31:0] top;
        logic signed [31:0] pick;
    } req_t;

    typedef struct packed {
        logic [29:0] value;
        logic        out_of_range;
    } res_t;

endpackage

`default_nettype wire

@@ hdl/modular_binomial_engine_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// modular_binomial_engine_unit: binomial, power and inverse modulo 998244353
// Factorial and inverse-factorial tables plus one shared modular multiplier
// run by a small sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   An item on request is taken at a clock edge with start high and busy
//   low. func selects binomial C(top, pick), power base^exponent or the
//   inverse of base. One result item per request appears on result for a
//   single cycle with done high; the receiver cannot stall it.
// Reset:
//   After rst_n the block stays busy while it fills the factorial table
//   (4096 entries), computes the top inverse factorial by a Fermat power
//   and sweeps the inverse table downward.
// Sequencing, all on the 5-stage shared multiplier:
//   binomial in range: two products; flagged or zero cases: no product.
//   power: one squaring per exponent bit and one more product per set
//   bit, up to a full 62-bit exponent.
//   inverse: a power with exponent P-2. busy drops in the cycle done
//   rises, so the next item can be taken while the result is out.
// ---------------------------------------------------------------------------
module modular_binomial_engine_unit
    import mbe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t request,
    output logic      busy,
    output logic      done,
    output res_t      result
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_FACT0     = 4'd1;
    localparam logic [3:0] ST_FACT_MUL  = 4'd2;
    localparam logic [3:0] ST_FACT_WAIT = 4'd3;
    localparam logic [3:0] ST_POW_CHK   = 4'd4;
    localparam logic [3:0] ST_POW_WA    = 4'd5;
    localparam logic [3:0] ST_POW_SQ    = 4'd6;
    localparam logic [3:0] ST_POW_WS    = 4'd7;
    localparam logic [3:0] ST_INV_MUL   = 4'd8;
    localparam logic [3:0] ST_INV_WAIT  = 4'd9;
    localparam logic [3:0] ST_BIN_RD2   = 4'd10;
    localparam logic [3:0] ST_BIN_W1    = 4'd11;
    localparam logic [3:0] ST_BIN_MUL2  = 4'd12;
    localparam logic [3:0] ST_BIN_W2    = 4'd13;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);

    logic [3:0]       state_reg, state_next;
    logic             init_reg, init_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [29:0]      run_reg, run_next;
    logic [29:0]      acc_reg, acc_next;
    logic [29:0]      sq_reg, sq_next;
    logic [61:0]      exp_reg, exp_next;
    logic [IDX_W-1:0] diff_reg, diff_next;
    logic             done_reg, done_next;
    res_t             result_reg, result_next;

    logic [29:0] fact_mem [TABLE_SIZE];
    logic [29:0] inv_mem [TABLE_SIZE];
    logic [29:0] fact_rd_reg, inv_rd_reg;
    logic             fact_we, inv_we, fact_re, inv_re;
    logic [IDX_W-1:0] fact_waddr, inv_waddr, fact_raddr, inv_raddr;
    logic [29:0]      fact_wdata, inv_wdata;

    logic        mul_start, mul_done;
    logic [29:0] mul_a, mul_b, mul_res;

    logic        top_neg, pick_neg, top_over, bin_ok;
    logic [29:0] base_red;
    logic [IDX_W-1:0] top_idx, pick_idx;

    mbe_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    // Decode the incoming binomial arguments
    assign top_neg  = request.top[31];
    assign pick_neg = request.pick[31];
    assign top_over = !top_neg && (request.top >= $signed(32'(TABLE_SIZE)));
    assign bin_ok   = !top_neg && !pick_neg && !top_over && (request.pick <= request.top);
    assign top_idx  = request.top[IDX_W-1:0];
    assign pick_idx = request.pick[IDX_W-1:0];
    assign base_red = (request.base >= MOD_P) ? request.base - MOD_P : request.base;

    // Table memories with registered reads
    always_ff @(posedge clk)
    begin
        if (fact_we)
        begin
            fact_mem[fact_waddr] <= fact_wdata;
        end
        if (fact_re)
        begin
            fact_rd_reg <= fact_mem[fact_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (inv_we)
        begin
            inv_mem[inv_waddr] <= inv_wdata;
        end
        if (inv_re)
        begin
            inv_rd_reg <= inv_mem[inv_raddr];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        init_next   = init_reg;
        idx_next    = idx_reg;
        run_next    = run_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        exp_next    = exp_reg;
        diff_next   = diff_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        mul_start   = 1'b0;
        mul_a       = run_reg;
        mul_b       = 30'(idx_reg);
        fact_we     = 1'b0;
        fact_waddr  = idx_reg;
        fact_wdata  = mul_res;
        inv_we      = 1'b0;
        inv_waddr   = idx_reg - 1'b1;
        inv_wdata   = mul_res;
        fact_re     = 1'b0;
        inv_re      = 1'b0;
        fact_raddr  = top_idx;
        inv_raddr   = pick_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (request.func) inside
                        FUNC_BINOM:
                        begin
                            if (bin_ok)
                            begin
                                fact_re    = 1'b1;
                                inv_re     = 1'b1;
                                diff_next  = top_idx - pick_idx;
                                state_next = ST_BIN_RD2;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = '{value: '0, out_of_range: top_over};
                            end
                        end
                        FUNC_POW, FUNC_INV:
                        begin
                            acc_next   = 30'd1;
                            sq_next    = base_red;
                            exp_next   = (request.func == FUNC_POW) ? request.exponent
                                                                    : 62'(MOD_P_M2);
                            state_next = ST_POW_CHK;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '{value: '0, out_of_range: 1'b0};
                        end
                    endcase
                end
            end
            ST_FACT0:
            begin
                fact_we    = 1'b1;
                fact_waddr = '0;
                fact_wdata = 30'd1;
                run_next   = 30'd1;
                idx_next   = IDX_W'(1);
                state_next = ST_FACT_MUL;
            end
            ST_FACT_MUL:
            begin
                mul_start  = 1'b1;
                state_next = ST_FACT_WAIT;
            end
            ST_FACT_WAIT:
            begin
                if (mul_done)
                begin
                    fact_we  = 1'b1;
                    run_next = mul_res;
                    if (idx_reg == IDX_LAST)
                    begin
                        acc_next   = 30'd1;
                        sq_next    = mul_res;
                        exp_next   = 62'(MOD_P_M2);
                        state_next = ST_POW_CHK;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_FACT_MUL;
                    end
                end
            end
            ST_POW_CHK:
            begin
                if (exp_reg == '0)
                begin
                    if (init_reg)
                    begin
                        inv_we     = 1'b1;
                        inv_waddr  = IDX_LAST;
                        inv_wdata  = acc_reg;
                        run_next   = acc_reg;
                        idx_next   = IDX_LAST;
                        state_next = ST_INV_MUL;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        result_next = '{value: acc_reg, out_of_range: 1'b0};
                        state_next  = ST_IDLE;
                    end
                end
                else if (exp_reg[0])
                begin
                    mul_start  = 1'b1;
                    mul_a      = acc_reg;
                    mul_b      = sq_reg;
                    state_next = ST_POW_WA;
                end
                else
                begin
                    state_next = ST_POW_SQ;
                end
            end
            ST_POW_WA:
            begin
                if (mul_done)
                begin
                    acc_next   = mul_res;
                    state_next = ST_POW_SQ;
                end
            end
            ST_POW_SQ:
            begin
                mul_start  = 1'b1;
                mul_a      = sq_reg;
                mul_b      = sq_reg;
                state_next = ST_POW_WS;
            end
            ST_POW_WS:
            begin
                if (mul_done)
                begin
                    sq_next    = mul_res;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_POW_CHK;
                end
            end
            ST_INV_MUL:
            begin
                mul_start  = 1'b1;
                state_next = ST_INV_WAIT;
            end
            ST_INV_WAIT:
            begin
                if (mul_done)
                begin
                    inv_we   = 1'b1;
                    run_next = mul_res;
                    if (idx_reg == IDX_W'(1))
                    begin
                        init_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_INV_MUL;
                    end
                end
            end
            ST_BIN_RD2:
            begin
                inv_re     = 1'b1;
                inv_raddr  = diff_reg;
                mul_start  = 1'b1;
                mul_a      = fact_rd_reg;
                mul_b      = inv_rd_reg;
                state_next = ST_BIN_W1;
            end
            ST_BIN_W1:
            begin
                if (mul_done)
                begin
                    run_next   = mul_res;
                    state_next = ST_BIN_MUL2;
                end
            end
            ST_BIN_MUL2:
            begin
                mul_start  = 1'b1;
                mul_a      = run_reg;
                mul_b      = inv_rd_reg;
                state_next = ST_BIN_W2;
            end
            ST_BIN_W2:
            begin
                if (mul_done)
                begin
                    done_next   = 1'b1;
                    result_next = '{value: mul_res, out_of_range: 1'b0};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FACT0;
            init_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        run_reg    <= run_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        exp_reg    <= exp_next;
        diff_reg   <= diff_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

@@ hdl/mbe_mulmod.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mbe_mulmod: pipelined modular multiplier
// Computes a*b mod P with a Barrett reduction over five register stages;
// one operand pair may enter per cycle, done marks the finished product.
// ---------------------------------------------------------------------------
module mbe_mulmod
    import mbe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [29:0] a,
    input  wire logic [29:0] b,
    output logic             done,
    output logic [29:0]      res
);

    logic [4:0]  valid_reg;
    logic [59:0] prod_reg;
    logic [61:0] q2_reg;
    logic [31:0] xlo_reg;
    logic [31:0] r_reg;
    logic [31:0] r1_reg;
    logic [29:0] r2_reg;
    logic [60:0] q3p;

    // Track items in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], start};
        end
    end

    assign q3p = q2_reg[61:31] * MOD_P;

    // Full product, quotient estimate, remainder, then two corrections
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        q2_reg   <= prod_reg[59:29] * BARRETT_M;
        xlo_reg  <= prod_reg[31:0];
        r_reg    <= xlo_reg - q3p[31:0];
        r1_reg   <= (r_reg >= {2'b00, MOD_P}) ? r_reg - {2'b00, MOD_P} : r_reg;
        r2_reg   <= (r1_reg >= {2'b00, MOD_P}) ? 30'(r1_reg - {2'b00, MOD_P})
                                               : r1_reg[29:0];
    end

    assign done = valid_reg[4];
    assign res  = r2_reg;

endmodule

`default_nettype wire
